@@ src/keystroke_suffix_rule_matcher_assert.svh @@
// Assertion macros used by the rule matcher sequencer.
`ifndef KEYSTROKE_SUFFIX_RULE_MATCHER_ASSERT_SVH
`define KEYSTROKE_SUFFIX_RULE_MATCHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KSRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KSRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KSRM_ASSERT_IMP(lbl, ante, cons, msg)
`define KSRM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/ksrm_pkg.sv @@
// Package with the sizes, codes, types and helper functions of the rule matcher.
package ksrm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_KEY     = 4;
    localparam int MAX_TEXT    = 4;
    localparam int FIELD_BYTES = 4;

    localparam int KEY_CAP  = (MAX_KEY < FIELD_BYTES) ? MAX_KEY : FIELD_BYTES;
    localparam int TEXT_CAP = (MAX_TEXT < FIELD_BYTES) ? MAX_TEXT : FIELD_BYTES;
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int HIST_W   = 8 * MAX_KEY;
    localparam int HCNT_W   = $clog2(MAX_KEY + 1);
    localparam int LEN_W    = 3;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 48;
    localparam int TUSER_W     = 2;

    localparam logic [7:0] OPEN_BRACKET = 8'h5B;

    // Action codes of an input item.
    localparam logic [1:0] ACT_KEY    = 2'd0;
    localparam logic [1:0] ACT_DEFINE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] STAT_NONE  = 2'd0;
    localparam logic [1:0] STAT_SUBST = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // One stored rule.
    typedef struct packed {
        logic [31:0]      key;
        logic [LEN_W-1:0] klen;
        logic [31:0]      text;
        logic [LEN_W-1:0] tlen;
        logic [3:0]       erase_before;
        logic [3:0]       erase_after;
        logic [3:0]       cursor_move;
    } t_rule;

    // One result item.
    typedef struct packed {
        logic [1:0]       status;
        logic [3:0]       erase_before;
        logic [3:0]       erase_after;
        logic [3:0]       cursor_move;
        logic [31:0]      insert_text;
        logic [LEN_W-1:0] insert_length;
        logic             indent_line;
    } t_result;

    // Access of the sequencer to the rule memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_rule             wr_data;
    } t_mem_req;

    // Cuts a length to the given capacity.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input int cap);
        logic [LEN_W-1:0] c;
        c = LEN_W'(cap);
        return (len > c) ? c : len;
    endfunction

    // Ones in every byte below the length.
    function automatic logic [31:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [31:0] m;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // True when the stored key is a prefix of the new key.
    function automatic logic is_prefix(input t_rule a, input logic [31:0] bkey,
                                       input logic [LEN_W-1:0] blen);
        logic hit;
        hit = (a.klen <= blen);
        for (int i = 0; i < FIELD_BYTES; i++) begin
            if (LEN_W'(i) < a.klen && a.key[8*i +: 8] != bkey[8*i +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // True when the key equals the newest characters of the history.
    function automatic logic suffix_hit(input logic [31:0] key,
                                        input logic [LEN_W-1:0] klen,
                                        input logic [HIST_W-1:0] hist,
                                        input logic [HCNT_W-1:0] hcnt);
        logic hit;
        int   idx;
        hit = (int'(klen) <= int'(hcnt));
        for (int i = 0; i < KEY_CAP; i++) begin
            idx = int'(klen) - 1 - i;
            if (LEN_W'(i) < klen && idx >= 0) begin
                if (hist[8*idx +: 8] != key[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    // True for the rule keyed by two open brackets.
    function automatic logic is_indent_key(input logic [31:0] key,
                                           input logic [LEN_W-1:0] klen);
        return (klen >= LEN_W'(2)) && (key[7:0] == OPEN_BRACKET) &&
               (key[15:8] == OPEN_BRACKET);
    endfunction

endpackage

@@ src/ksrm_rule_mem.sv @@
// Rule table memory with one write port and one registered read port.
module ksrm_rule_mem (
    input  logic             i_clk,
    input  ksrm_pkg::t_mem_req i_req,
    output ksrm_pkg::t_rule  o_rd_data
);
    import ksrm_pkg::*;

    t_rule r_mem [TABLE_DEPTH];
    t_rule r_rd_data;

    // Write and read; read data comes from a register and appears in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/ksrm_seq.sv @@
// Sequencer: history, rule count, table scans and the insert shift.
module ksrm_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_action,
    input  logic [7:0]               i_char,
    input  ksrm_pkg::t_rule          i_rule,
    output ksrm_pkg::t_mem_req       o_mem_req,
    input  ksrm_pkg::t_rule          i_rd_data,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output ksrm_pkg::t_result        o_res
);
    import ksrm_pkg::*;

    `include "keystroke_suffix_rule_matcher_assert.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [HIST_W-1:0] r_hist, n_hist;
    logic [HCNT_W-1:0] r_hcnt, n_hcnt;
    t_rule             r_new, n_new;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_src, n_src;
    t_result           r_res, n_res;

    logic [LEN_W-1:0]  new_klen;
    logic [LEN_W-1:0]  new_tlen;
    logic              hit_find;
    logic              hit_scan;
    logic [CNT_W-1:0]  shift_src;
    logic [CNT_W-1:0]  shift_dst;
    t_mem_req          mem_req;
    logic              accept;

    assign new_klen = clamp_len(i_rule.klen, KEY_CAP);
    assign new_tlen = clamp_len(i_rule.tlen, TEXT_CAP);
    assign hit_find = is_prefix(i_rd_data, r_new.key, r_new.klen);
    assign hit_scan = suffix_hit(i_rd_data.key, i_rd_data.klen, r_hist, r_hcnt);
    assign shift_src = r_src - CNT_W'(1);
    assign shift_dst = CNT_W'(r_pidx) + CNT_W'(1);
    assign accept   = i_valid && (r_state == S_IDLE);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_hist  = r_hist;
        n_hcnt  = r_hcnt;
        n_new   = r_new;
        n_issue = r_issue;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_pos   = r_pos;
        n_src   = r_src;
        n_res   = r_res;
        mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_res   = '0;
                    case (i_action)
                        ACT_DEFINE: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res.status = STAT_FULL;
                                n_state      = S_RESULT;
                            end else begin
                                n_new.key          = i_rule.key & byte_mask(new_klen);
                                n_new.klen         = new_klen;
                                n_new.text         = i_rule.text & byte_mask(new_tlen);
                                n_new.tlen         = new_tlen;
                                n_new.erase_before = i_rule.erase_before;
                                n_new.erase_after  = i_rule.erase_after;
                                n_new.cursor_move  = i_rule.cursor_move;
                                n_state            = S_FIND;
                            end
                        end
                        ACT_KEY: begin
                            n_hist = {r_hist[HIST_W-9:0], i_char};
                            if (r_hcnt < HCNT_W'(MAX_KEY)) begin
                                n_hcnt = r_hcnt + HCNT_W'(1);
                            end
                            n_state = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_hist  = '0;
                            n_hcnt  = '0;
                            n_state = S_RESULT;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end

            // Look for the first stored key that is a prefix of the new key.
            S_FIND: begin
                if (r_pend && hit_find) begin
                    n_pos   = CNT_W'(r_pidx);
                    n_src   = r_count;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else if (r_issue < r_count) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_issue[ADDR_W-1:0];
                    n_pidx          = r_issue[ADDR_W-1:0];
                    n_issue         = r_issue + CNT_W'(1);
                    n_pend          = 1'b1;
                end else begin
                    n_pos   = r_count;
                    n_src   = r_count;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end

            // Move rules down one place from the end, then write the new rule.
            // Reads run two entries below the writes, so they never overlap.
            S_SHIFT: begin
                n_pend = 1'b0;
                if (r_pend) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = shift_dst[ADDR_W-1:0];
                    mem_req.wr_data = i_rd_data;
                end
                if (r_src > r_pos) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = shift_src[ADDR_W-1:0];
                    n_pidx          = shift_src[ADDR_W-1:0];
                    n_src           = shift_src;
                    n_pend          = 1'b1;
                end else if (!r_pend) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pos[ADDR_W-1:0];
                    mem_req.wr_data = r_new;
                    n_count         = r_count + CNT_W'(1);
                    n_res           = '0;
                    n_state         = S_RESULT;
                end
            end

            // Find the first rule whose key matches the history's suffix.
            S_SCAN: begin
                if (r_pend && hit_scan) begin
                    n_res.status        = STAT_SUBST;
                    n_res.erase_before  = i_rd_data.erase_before;
                    n_res.erase_after   = i_rd_data.erase_after;
                    n_res.cursor_move   = i_rd_data.cursor_move;
                    n_res.insert_text   = i_rd_data.text;
                    n_res.insert_length = i_rd_data.tlen;
                    n_res.indent_line   = is_indent_key(i_rd_data.key, i_rd_data.klen);
                    n_pend              = 1'b0;
                    n_state             = S_RESULT;
                end else if (r_issue < r_count) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_issue[ADDR_W-1:0];
                    n_pidx          = r_issue[ADDR_W-1:0];
                    n_issue         = r_issue + CNT_W'(1);
                    n_pend          = 1'b1;
                end else begin
                    n_res   = '0;
                    n_pend  = 1'b0;
                    n_state = S_RESULT;
                end
            end

            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hist  <= '0;
            r_hcnt  <= '0;
            r_issue <= '0;
            r_pend  <= 1'b0;
            r_pos   <= '0;
            r_src   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hist  <= n_hist;
            r_hcnt  <= n_hcnt;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_pos   <= n_pos;
            r_src   <= n_src;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_new  <= n_new;
        r_pidx <= n_pidx;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_mem_req   = mem_req;
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    `KSRM_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "rule count past depth")
    `KSRM_ASSERT_IMP(a_hist_bound, 1'b1, r_hcnt <= HCNT_W'(MAX_KEY), "history count past limit")
    `KSRM_ASSERT_IMP(a_write_shift, mem_req.wr_en, r_state == S_SHIFT, "table write outside shift")
    `KSRM_ASSERT_NXT(a_accept_busy, i_valid && o_ready, r_state != S_IDLE, "accepted item lost")
    `KSRM_ASSERT_NXT(a_count_step, r_state == S_SHIFT && !r_pend && r_src <= r_pos,
                     r_count == $past(r_count) + CNT_W'(1), "insert did not add one rule")

endmodule

@@ src/keystroke_suffix_rule_matcher.sv @@
// Top level of the keystroke suffix rule matcher: stream ports and result register.
// A keystroke's result comes from the scan that reads one rule a cycle from the rule memory
// and stops at the first matching rule.
// A define runs a prefix search, then the shift that moves one rule a cycle; a define on a
// full table, clear and unknown actions go straight to the result.
// One item is in work at a time; a result waits in the output register meanwhile.
// Synchronous active-low reset empties the table and the history; no clearing pass.
module keystroke_suffix_rule_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // character, rule_key, rule_key_length, rule_text, rule_text_length,
    // rule_erase_before, rule_erase_after, rule_cursor_move, zero pad
    input  logic [ksrm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // action
    input  logic [ksrm_pkg::TUSER_W-1:0]     i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // erase_before, erase_after, cursor_move, insert_text, insert_length, indent_line
    output logic [ksrm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [ksrm_pkg::TUSER_W-1:0]     o_m_tuser
);
    import ksrm_pkg::*;

    t_rule     in_rule;
    t_mem_req  mem_req;
    t_rule     rd_data;
    logic      res_valid;
    logic      res_ready;
    t_result   res;
    logic      r_out_valid;
    t_result   r_out;

    // Unpack the rule fields of an input item.
    always_comb begin
        in_rule.key          = i_s_tdata[39:8];
        in_rule.klen         = i_s_tdata[42:40];
        in_rule.text         = i_s_tdata[74:43];
        in_rule.tlen         = i_s_tdata[77:75];
        in_rule.erase_before = i_s_tdata[81:78];
        in_rule.erase_after  = i_s_tdata[85:82];
        in_rule.cursor_move  = i_s_tdata[89:86];
    end

    ksrm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_char      (i_s_tdata[7:0]),
        .i_rule      (in_rule),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    ksrm_rule_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Output register: takes a result when empty or being drained.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.indent_line, r_out.insert_length, r_out.insert_text,
                         r_out.cursor_move, r_out.erase_after, r_out.erase_before};
    assign o_m_tuser  = r_out.status;

endmodule

@@ tb/tb_keystroke_suffix_rule_matcher.sv @@
// Self-checking testbench of the keystroke suffix rule matcher, with its own rule table predictor.
module tb_keystroke_suffix_rule_matcher;
    import ksrm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int DIR_N        = 25;
    localparam int RAND_N       = 425;
    localparam int PAUSE_AT     = 200;
    localparam int EMPTY_AT     = 340;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_LEN     = 150;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;

    // One input item, plus a flag for rows whose expected result is all zeros.
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  ch;
        logic [31:0] key;
        logic [2:0]  klen;
        logic [31:0] text;
        logic [2:0]  tlen;
        logic [3:0]  erase_before;
        logic [3:0]  erase_after;
        logic [3:0]  cursor_move;
        logic        typed;
    } t_kitem;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [TUSER_W-1:0]     i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [TUSER_W-1:0]     o_m_tuser;

    // Predicted copy of the rule table and the keystroke history.
    logic [31:0]         rule_key  [TABLE_DEPTH];
    logic [2:0]          rule_klen [TABLE_DEPTH];
    logic [31:0]         rule_text [TABLE_DEPTH];
    logic [2:0]          rule_tlen [TABLE_DEPTH];
    logic [11:0]         rule_edit [TABLE_DEPTH];
    int                  n_rules;
    logic [8*MAX_KEY-1:0] recent;
    int                  n_recent;

    t_result substitutions_due[$];
    t_kitem  dir_rows[DIR_N];
    int      n_accepted;
    int      n_results;
    int      n_mismatch;
    int      n_cycles;
    int      snd_idle;
    int      rcv_idle;
    int      hold_left;
    bit      hold_done;

    keystroke_suffix_rule_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [2:0] cap_length(input logic [2:0] len, input int limit);
        int cap;
        cap = (limit < 4) ? limit : 4;
        return (int'(len) > cap) ? 3'(cap) : len;
    endfunction

    function automatic logic [31:0] low_bytes_mask(input logic [2:0] len);
        logic [31:0] m;
        for (int i = 0; i < 4; i++)
            m[8*i +: 8] = (i < int'(len)) ? 8'hFF : 8'h00;
        return m;
    endfunction

    // Applies one item to the predicted table and history and returns its result.
    function automatic t_result predict_substitution(input t_kitem it);
        t_result     res;
        logic [2:0]  kl;
        logic [2:0]  tl;
        logic [31:0] kb;
        int          pos;
        int          len_i;
        int          idx;
        bit          hit;
        bit          found;
        res = '0;
        found = 1'b0;
        case (it.action)
            ACT_DEFINE: begin
                if (n_rules >= TABLE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    kl = cap_length(it.klen, MAX_KEY);
                    tl = cap_length(it.tlen, MAX_TEXT);
                    kb = it.key & low_bytes_mask(kl);
                    pos = n_rules;
                    // The new rule goes ahead of the first stored key that is a prefix of it.
                    for (int i = 0; i < n_rules; i++) begin
                        len_i = rule_klen[i];
                        hit = !found && (len_i <= int'(kl));
                        for (int j = 0; j < 4; j++)
                            if (j < len_i && rule_key[i][8*j +: 8] != kb[8*j +: 8])
                                hit = 1'b0;
                        if (hit) begin
                            pos = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = n_rules; i > pos; i--) begin
                        rule_key[i]  = rule_key[i-1];
                        rule_klen[i] = rule_klen[i-1];
                        rule_text[i] = rule_text[i-1];
                        rule_tlen[i] = rule_tlen[i-1];
                        rule_edit[i] = rule_edit[i-1];
                    end
                    rule_key[pos]  = kb;
                    rule_klen[pos] = kl;
                    rule_text[pos] = it.text & low_bytes_mask(tl);
                    rule_tlen[pos] = tl;
                    rule_edit[pos] = {it.cursor_move, it.erase_after, it.erase_before};
                    n_rules++;
                end
            end
            ACT_CLEAR: begin
                recent = '0;
                n_recent = 0;
            end
            ACT_KEY: begin
                recent = {recent[8*MAX_KEY-9:0], it.ch};
                if (n_recent < MAX_KEY)
                    n_recent++;
                // First rule in table order whose key equals the newest characters wins.
                for (int i = 0; i < n_rules; i++) begin
                    len_i = rule_klen[i];
                    hit = !found && (len_i <= n_recent);
                    for (int j = 0; j < 4; j++) begin
                        idx = len_i - 1 - j;
                        if (j < len_i && recent[8*idx +: 8] != rule_key[i][8*j +: 8])
                            hit = 1'b0;
                    end
                    if (hit) begin
                        found = 1'b1;
                        res.status        = STAT_SUBST;
                        res.erase_before  = rule_edit[i][3:0];
                        res.erase_after   = rule_edit[i][7:4];
                        res.cursor_move   = rule_edit[i][11:8];
                        res.insert_text   = rule_text[i];
                        res.insert_length = rule_tlen[i];
                        res.indent_line   = (len_i >= 2) &&
                                            (rule_key[i][7:0] == OPEN_BRACKET) &&
                                            (rule_key[i][15:8] == OPEN_BRACKET);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly a small alphabet so that keys and keystrokes meet; now and then any byte.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1:    return 8'h61;
            2, 3:    return 8'h62;
            4, 5:    return OPEN_BRACKET;
            6:       return 8'h00;
            7:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random item; defines fill the table slowly and the empty key comes last.
    function automatic t_kitem random_item(input int k);
        t_kitem it;
        int     roll;
        bit     define_ok;
        it.ch           = 8'($urandom);
        it.key          = $urandom;
        it.klen         = 3'($urandom);
        it.text         = $urandom;
        it.tlen         = 3'($urandom);
        it.erase_before = 4'($urandom);
        it.erase_after  = 4'($urandom);
        it.cursor_move  = 4'($urandom);
        it.typed        = 1'b0;
        define_ok = (n_rules != TABLE_DEPTH - 1) || (k >= EMPTY_AT);
        roll = $urandom_range(99);
        if (roll < 3) begin
            it.action = ACT_UNUSED;
        end else if (roll < 12) begin
            it.action = ACT_CLEAR;
        end else if (roll < 18 && define_ok) begin
            it.action = ACT_DEFINE;
            if (n_rules == TABLE_DEPTH - 1) begin
                it.klen = 3'd0;
            end else if (n_rules < TABLE_DEPTH - 1) begin
                it.klen = ($urandom_range(3) == 0) ? 3'($urandom_range(7, 5))
                                                   : 3'($urandom_range(4, 1));
                for (int j = 0; j < 4; j++)
                    if (j < int'(it.klen))
                        it.key[8*j +: 8] = pick_char();
            end
        end else begin
            it.action = ACT_KEY;
            it.ch = pick_char();
        end
        return it;
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("%s (result %0d): expected st=%0d eb=%0d ea=%0d cm=%0d text=%h len=%0d ind=%0d",
                     what, n_results, want.status, want.erase_before, want.erase_after,
                     want.cursor_move, want.insert_text, want.insert_length, want.indent_line);
            $display("    actual st=%0d eb=%0d ea=%0d cm=%0d text=%h len=%0d ind=%0d",
                     got.status, got.erase_before, got.erase_after, got.cursor_move,
                     got.insert_text, got.insert_length, got.indent_line);
        end
    endtask

    // Offers one item after a random gap and records its expected result on acceptance.
    task automatic offer_item(input t_kitem it);
        int      gap;
        t_result pred;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < snd_idle)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.action;
        i_s_tdata  <= {6'd0, it.cursor_move, it.erase_after, it.erase_before, it.tlen,
                       it.text, it.klen, it.key, it.ch};
        do @(posedge i_clk); while (!o_s_tready);
        pred = predict_substitution(it);
        substitutions_due.push_back(it.typed ? t_result'('0) : pred);
        n_accepted++;
    endtask

    // Result side: random stalls, one long hold-off, and the comparison of each item.
    always @(posedge i_clk) begin : result_check
        t_result got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.status        = o_m_tuser;
                got.erase_before  = o_m_tdata[3:0];
                got.erase_after   = o_m_tdata[7:4];
                got.cursor_move   = o_m_tdata[11:8];
                got.insert_text   = o_m_tdata[43:12];
                got.insert_length = o_m_tdata[46:44];
                got.indent_line   = o_m_tdata[47];
                n_results++;
                if (substitutions_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else if (got.status        !== substitutions_due[0].status ||
                             got.erase_before  !== substitutions_due[0].erase_before ||
                             got.erase_after   !== substitutions_due[0].erase_after ||
                             got.cursor_move   !== substitutions_due[0].cursor_move ||
                             got.insert_text   !== substitutions_due[0].insert_text ||
                             got.insert_length !== substitutions_due[0].insert_length ||
                             got.indent_line   !== substitutions_due[0].indent_line) begin
                    note_mismatch("mismatch", substitutions_due[0], got);
                    void'(substitutions_due.pop_front());
                end else begin
                    void'(substitutions_due.pop_front());
                end
            end
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        n_rules    = 0;
        recent     = '0;
        n_recent   = 0;
        n_accepted = 0;
        n_results  = 0;
        n_mismatch = 0;
        n_cycles   = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        snd_idle   = 16;
        rcv_idle   = 52;

        // action, char, key, key len, text, text len, erase before/after, move, typed
        dir_rows = '{
            // Keystroke on an empty table, unknown action, clear.
            '{ACT_KEY,    8'h61, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b1},
            '{ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 3'd7, 4'hF, 4'hF, 4'hF, 1'b1},
            '{ACT_CLEAR,  8'h00, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b1},
            // "ab" with overlong text, "[[" with junk above its text, "b" with empty text.
            '{ACT_DEFINE, 8'h00, 32'hFFFF_6261, 3'd2, 32'hFFFF_FFFF, 3'd7, 4'hF, 4'hF, 4'hF, 1'b1},
            '{ACT_DEFINE, 8'h00, 32'h0000_5B5B, 3'd2, 32'hDEAD_BE78, 3'd1, 4'd0, 4'd0, 4'd0, 1'b1},
            '{ACT_DEFINE, 8'h00, 32'h0000_0062, 3'd1, 32'h1234_5678, 3'd0, 4'd1, 4'd2, 4'd3, 1'b1},
            // Overlong key "abcd" lands ahead of its prefix "ab"; then a zero-byte key.
            '{ACT_DEFINE, 8'h00, 32'h6463_6261, 3'd7, 32'h0000_0000, 3'd4, 4'd8, 4'd4, 4'd2, 1'b1},
            '{ACT_DEFINE, 8'h00, 32'hFFFF_FF00, 3'd1, 32'h0000_0041, 3'd1, 4'd5, 4'hA, 4'hF, 1'b1},
            '{ACT_CLEAR,  8'h00, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b1},
            // Short history, then "ab", "abcd", the zero byte and "[[".
            '{ACT_KEY,    8'h61, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h62, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h63, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h64, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h00, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h5B, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h5B, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            // Long history: "abcd" again after more than four characters.
            '{ACT_KEY,    8'h61, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h62, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h63, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h64, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'hFF, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            // "[[[" goes ahead of "[[" and also raises the indent flag.
            '{ACT_DEFINE, 8'h00, 32'h005B_5B5B, 3'd3, 32'h7D7D_0A20, 3'd4, 4'd0, 4'd2, 4'd1, 1'b1},
            '{ACT_KEY,    8'h5B, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h5B, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0},
            '{ACT_KEY,    8'h5B, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 4'd0, 4'd0, 4'd0, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++)
            offer_item(dir_rows[r]);

        // Random part in three idling phases, with one pause until the block drains.
        for (int k = 0; k < RAND_N; k++) begin
            if (k == 150) begin
                snd_idle = 52;
                rcv_idle = 16;
            end
            if (k == 300) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if (k == PAUSE_AT) begin
                i_s_tvalid <= 1'b0;
                while (substitutions_due.size() != 0) @(posedge i_clk);
            end
            offer_item(random_item(k));
        end
        i_s_tvalid <= 1'b0;

        while (substitutions_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/ksrm_pkg.sv
src/ksrm_rule_mem.sv
src/ksrm_seq.sv
src/keystroke_suffix_rule_matcher.sv
tb/tb_keystroke_suffix_rule_matcher.sv
